/* rtl/rbls_pkg.sv */
// Shared types and fixed constants for the RGB565 bilinear letterbox scaler.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package rbls_pkg;

   localparam int POS_W       = 9;   // coordinate field width
   localparam int PIX_W       = 16;  // RGB565 pixel width
   localparam int FRAC_W      = 5;   // bilinear fraction width
   localparam int QUEUE_DEPTH = 4;   // front-to-back queue entries

   // Request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // What the back end does with a queue entry
   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,   // store pixel into the canvas
      KIND_SCALED = 2'd1,   // fetch four neighbors and blend
      KIND_CONST  = 2'd2    // answer with a fixed pixel (black or bar)
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [FRAC_W-1:0]   fx;
      logic [FRAC_W-1:0]   fy;
      logic                x_odd;    // parity of left column
      logic                x_edge;   // left column is the last one
      logic                y_odd;    // parity of upper row
      logic                y_edge;   // upper row is the last one
      logic [PIX_W-1:0]    pixel;    // write data or constant answer
   } entry_ctl_type;

endpackage

`default_nettype wire

/* rtl/rgb565_bilinear_letterbox_scaler_unit.sv */
// Top level of the RGB565 bilinear letterbox scaler.
// Uses rbls_pkg, rbls_front, rbls_queue and rbls_back.
//
// Usage:
//   req_ channel (push/full): func 0 stores req_write_pixel into the source
//     canvas at (pos_x, pos_y); func 1 asks for output frame pixel
//     (pos_x, pos_y). Writes outside the canvas are dropped silently.
//   rsp_ channel (empty/pop): one rsp_frame_pixel per read, in request
//     order: bilinear scaled inside the centered window, black outside,
//     red bar on top when alert_bar_enable is set. Writes give no response.
//   csr_ channel (valid/ready): writes alert_bar_enable; ready is always
//     high. Write it only while no request is in flight.
//   Path: a read goes through the front register, a queue slot, the bank
//     read register, the horizontal blend register and the result register
//     before it shows up on the rsp_ ports.
//   Throughput: one request per cycle unless rsp_ stalls, set by the single
//     read port of each of the four row/column parity banks holding the canvas.
//   Reset clears the pipelines, the queue and the bar enable. Canvas
//     contents stay undefined until written; no clearing pass.
//   When the receiver stalls, the back end freezes, the front end keeps
//   accepting until its register and the four-entry queue fill, then full.
`default_nettype none

module rgb565_bilinear_letterbox_scaler_unit
   import rbls_pkg::*;
#(
   parameter int SRC_W   = 184,
   parameter int SRC_H   = 224,
   parameter int OUT_W   = 368,
   parameter int OUT_H   = 448,
   parameter int FRAME_W = 480,
   parameter int FRAME_H = 480
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output      logic              req_full,
   input  wire logic              req_func,
   input  wire logic [POS_W-1:0]  req_pos_x,
   input  wire logic [POS_W-1:0]  req_pos_y,
   input  wire logic [PIX_W-1:0]  req_write_pixel,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      logic [PIX_W-1:0]  rsp_frame_pixel,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic              csr_alert_bar_enable
);

   // bank geometry: canvas split by row and column parity
   localparam int BANK_W = (SRC_W + 1) / 2;
   localparam int BANK_H = (SRC_H + 1) / 2;
   localparam int BANK_D = BANK_W * BANK_H;
   localparam int BA_W   = (BANK_D > 1) ? $clog2(BANK_D) : 1;
   localparam int ENT_W  = $bits(entry_ctl_type) + 4 * BA_W;

   // control register
   logic alert_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alert_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         alert_en_ff <= csr_alert_bar_enable;
      end
   end

   // front end: classify and map
   logic                  q_push, q_full, q_pop, q_empty;
   entry_ctl_type         ent_ctl, q_ctl;
   logic [3:0][BA_W-1:0]  ent_addr, q_addr;
   logic [ENT_W-1:0]      q_wdata, q_rdata;

   rbls_front #(
      .SRC_W   (SRC_W),
      .SRC_H   (SRC_H),
      .OUT_W   (OUT_W),
      .OUT_H   (OUT_H),
      .FRAME_W (FRAME_W),
      .FRAME_H (FRAME_H)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_write_pixel (req_write_pixel),
      .alert_en        (alert_en_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .ent_ctl         (ent_ctl),
      .ent_addr        (ent_addr)
   );

   // decoupling queue: entry = control fields plus four bank addresses
   assign q_wdata          = {ent_ctl, ent_addr};
   assign {q_ctl, q_addr}  = q_rdata;

   rbls_queue #(
      .WIDTH (ENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wdata),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rdata),
      .empty   (q_empty)
   );

   // back end: canvas banks, blend, result register
   rbls_back #(
      .SRC_W (SRC_W),
      .SRC_H (SRC_H)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_ctl           (q_ctl),
      .q_addr          (q_addr),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_frame_pixel (rsp_frame_pixel)
   );

endmodule

`default_nettype wire

/* rtl/rbls_front.sv */
// Front end: accepts requests, classifies them and maps frame coordinates
// to canvas neighbors and bank addresses. Depends on rbls_pkg.
`default_nettype none

module rbls_front
   import rbls_pkg::*;
#(
   parameter int SRC_W   = 184,
   parameter int SRC_H   = 224,
   parameter int OUT_W   = 368,
   parameter int OUT_H   = 448,
   parameter int FRAME_W = 480,
   parameter int FRAME_H = 480
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output      logic                 req_full,
   input  wire logic                 req_func,
   input  wire logic [POS_W-1:0]     req_pos_x,
   input  wire logic [POS_W-1:0]     req_pos_y,
   input  wire logic [PIX_W-1:0]     req_write_pixel,
   input  wire logic                 alert_en,
   input  wire logic                 q_full,
   output      logic                 q_push,
   output      entry_ctl_type        ent_ctl,
   output      logic [3:0][((((SRC_W+1)/2)*((SRC_H+1)/2)) > 1 ?
                         $clog2(((SRC_W+1)/2)*((SRC_H+1)/2)) : 1)-1:0] ent_addr
);

   localparam logic [PIX_W-1:0] BAR_COLOR  = 16'hF800;
   localparam logic [PIX_W-1:0] BLACK      = 16'h0000;
   localparam int               BAR_WIDTH  = 200;
   localparam int               BAR_TOP    = 18;
   localparam int               BAR_HEIGHT = 8;
   localparam int               BAR_X0     = (FRAME_W - BAR_WIDTH) / 2;

   localparam int WIN_X0 = (FRAME_W - OUT_W) / 2;
   localparam int WIN_Y0 = (FRAME_H - OUT_H) / 2;

   localparam int DX_W  = $clog2((2**POS_W) + OUT_W + FRAME_W) + 1;
   localparam int DY_W  = $clog2((2**POS_W) + OUT_H + FRAME_H) + 1;
   localparam int DXU_W = $clog2(OUT_W);
   localparam int DYU_W = $clog2(OUT_H);

   localparam longint FACTOR_X = (longint'(SRC_W) << 16) / OUT_W;
   localparam longint FACTOR_Y = (longint'(SRC_H) << 16) / OUT_H;
   localparam int     FXF_W    = $clog2(FACTOR_X + 1);
   localparam int     FYF_W    = $clog2(FACTOR_Y + 1);
   localparam int     SX_W     = (DXU_W + FXF_W > 16) ? DXU_W + FXF_W : 17;
   localparam int     SY_W     = (DYU_W + FYF_W > 16) ? DYU_W + FYF_W : 17;

   localparam int XS_W   = $clog2(SRC_W);
   localparam int YS_W   = $clog2(SRC_H);
   localparam int BANK_W = (SRC_W + 1) / 2;
   localparam int BANK_H = (SRC_H + 1) / 2;
   localparam int BANK_D = BANK_W * BANK_H;
   localparam int BA_W   = (BANK_D > 1) ? $clog2(BANK_D) : 1;
   localparam int XH_W   = (BANK_W > 1) ? $clog2(BANK_W) : 1;
   localparam int YH_W   = (BANK_H > 1) ? $clog2(BANK_H) : 1;

   // ---- stage A: classify and multiply ----
   logic                  is_write, wr_ok, in_frame, in_x, in_y, in_win, on_bar;
   logic                  keep, accept, adv;
   logic signed [DX_W-1:0] dx;
   logic signed [DY_W-1:0] dy;
   logic [SX_W-1:0]       sx_in;
   logic [SY_W-1:0]       sy_in;
   kind_type              kind_in;
   logic [PIX_W-1:0]      pixel_in;

   logic                  valid_ff;
   kind_type              kind_ff;
   logic [PIX_W-1:0]      pixel_ff;
   logic [SX_W-1:0]       sx_ff;
   logic [SY_W-1:0]       sy_ff;
   logic [XS_W-1:0]       wx_ff;
   logic [YS_W-1:0]       wy_ff;

   always_comb begin
      is_write = (req_func == FUNC_WRITE);
      wr_ok    = (int'(req_pos_x) < SRC_W) && (int'(req_pos_y) < SRC_H);
      in_frame = (int'(req_pos_x) < FRAME_W) && (int'(req_pos_y) < FRAME_H);
      dx       = DX_W'(int'(req_pos_x) - WIN_X0);
      dy       = DY_W'(int'(req_pos_y) - WIN_Y0);
      in_x     = !dx[DX_W-1] && (dx < $signed(DX_W'(OUT_W)));
      in_y     = !dy[DY_W-1] && (dy < $signed(DY_W'(OUT_H)));
      in_win   = in_frame && in_x && in_y;
      on_bar   = alert_en && in_frame &&
                 (int'(req_pos_y) >= BAR_TOP) &&
                 (int'(req_pos_y) < BAR_TOP + BAR_HEIGHT) &&
                 (int'(req_pos_x) >= BAR_X0) &&
                 (int'(req_pos_x) < BAR_X0 + BAR_WIDTH);
      sx_in    = SX_W'(dx[DXU_W-1:0]) * SX_W'(FACTOR_X);
      sy_in    = SY_W'(dy[DYU_W-1:0]) * SY_W'(FACTOR_Y);

      if (is_write) begin
         kind_in  = KIND_WRITE;
         pixel_in = req_write_pixel;
      end else if (on_bar) begin
         kind_in  = KIND_CONST;
         pixel_in = BAR_COLOR;
      end else if (in_win) begin
         kind_in  = KIND_SCALED;
         pixel_in = BLACK;
      end else begin
         kind_in  = KIND_CONST;
         pixel_in = BLACK;
      end

      // writes that miss the canvas vanish here
      keep     = !is_write || wr_ok;
      adv      = !valid_ff || !q_full;
      req_full = !adv;
      accept   = req_push && adv;
      q_push   = valid_ff && !q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= accept && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && accept) begin
         kind_ff  <= kind_in;
         pixel_ff <= pixel_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         wx_ff    <= XS_W'(req_pos_x);
         wy_ff    <= YS_W'(req_pos_y);
      end
   end

   // ---- stage B: neighbors, fractions and bank addresses ----
   logic [SX_W-17:0]  ipx;
   logic [SY_W-17:0]  ipy;
   logic [XS_W-1:0]   x0;
   logic [YS_W-1:0]   y0;
   logic              x_odd, x_edge, y_odd, y_edge;
   logic [XH_W-1:0]   ch_e, ch_o;
   logic [YH_W-1:0]   rh_e, rh_o;
   logic [BA_W-1:0]   rbase_e, rbase_o;

   always_comb begin
      ipx = sx_ff[SX_W-1:16];
      ipy = sy_ff[SY_W-1:16];
      ent_ctl = '0;
      if (kind_ff == KIND_WRITE) begin
         x0 = wx_ff;
         y0 = wy_ff;
      end else begin
         x0 = (32'(ipx) > 32'(SRC_W - 1)) ? XS_W'(SRC_W - 1) : XS_W'(ipx);
         y0 = (32'(ipy) > 32'(SRC_H - 1)) ? YS_W'(SRC_H - 1) : YS_W'(ipy);
         ent_ctl.fx = sx_ff[15:11];
         ent_ctl.fy = sy_ff[15:11];
      end
      x_odd  = x0[0];
      y_odd  = y0[0];
      x_edge = (x0 == XS_W'(SRC_W - 1));
      y_edge = (y0 == YS_W'(SRC_H - 1));

      // odd bank always takes x0>>1; even bank steps past an odd x0 unless it is the last
      ch_o = XH_W'(x0 >> 1);
      ch_e = XH_W'(x0 >> 1) + XH_W'(x_odd && !x_edge);
      rh_o = YH_W'(y0 >> 1);
      rh_e = YH_W'(y0 >> 1) + YH_W'(y_odd && !y_edge);

      rbase_e = BA_W'(rh_e) * BA_W'(BANK_W);
      rbase_o = BA_W'(rh_o) * BA_W'(BANK_W);
      ent_addr[0] = rbase_e + BA_W'(ch_e);
      ent_addr[1] = rbase_e + BA_W'(ch_o);
      ent_addr[2] = rbase_o + BA_W'(ch_e);
      ent_addr[3] = rbase_o + BA_W'(ch_o);

      ent_ctl.kind   = kind_ff;
      ent_ctl.x_odd  = x_odd;
      ent_ctl.x_edge = x_edge;
      ent_ctl.y_odd  = y_odd;
      ent_ctl.y_edge = y_edge;
      ent_ctl.pixel  = pixel_ff;
   end

`ifndef SYNTHESIS
   // an off-canvas write must not reach the queue
   assert property (@(posedge clock) disable iff (reset)
      (accept && is_write && !wr_ok) |=> !valid_ff)
      else $error("off-canvas write entered the front register");
`endif

endmodule

`default_nettype wire

/* rtl/rbls_queue.sv */
// Small register FIFO that decouples the front end from the back end.
// Depends on rbls_pkg for the default depth QUEUE_DEPTH.
`default_nettype none

module rbls_queue
   import rbls_pkg::*;
#(
   parameter int WIDTH = 64,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] rd_data,
   output      logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      empty     = (count_ff == '0);
      rd_data   = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* rtl/rbls_back.sv */
// Back end: four parity banks of the canvas, bilinear blend pipeline and
// the result register. Depends on rbls_pkg.
`default_nettype none

module rbls_back
   import rbls_pkg::*;
#(
   parameter int SRC_W = 184,
   parameter int SRC_H = 224
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire entry_ctl_type        q_ctl,
   input  wire logic [3:0][((((SRC_W+1)/2)*((SRC_H+1)/2)) > 1 ?
                         $clog2(((SRC_W+1)/2)*((SRC_H+1)/2)) : 1)-1:0] q_addr,
   output      logic                 q_pop,
   input  wire logic                 rsp_pop,
   output      logic                 rsp_empty,
   output      logic [PIX_W-1:0]     rsp_frame_pixel
);

   localparam int BANK_W = (SRC_W + 1) / 2;
   localparam int BANK_H = (SRC_H + 1) / 2;
   localparam int BANK_D = BANK_W * BANK_H;

   localparam logic [PIX_W-1:0] RB_MASK = 16'hF81F;
   localparam logic [PIX_W-1:0] G_MASK  = 16'h07E0;
   localparam int W_W    = FRAC_W + 1;          // weight 0..32
   localparam int HRB_W  = PIX_W + FRAC_W;      // 21
   localparam int HG_W   = 11 + FRAC_W;         // 16
   localparam int VRB_W  = HRB_W + FRAC_W;      // 26
   localparam int VG_W   = HG_W + FRAC_W;       // 21
   localparam int BLEND_SHIFT = 10;
   localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(32);

   logic adv;
   logic [3:0] bank_we;
   logic [PIX_W-1:0] rdata_ff [4];

   assign adv   = rsp_empty || rsp_pop;
   assign q_pop = adv && !q_empty;

   // ---- stage 1: bank write / read ----
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [PIX_W-1:0] mem [BANK_D];

      assign bank_we[b] = q_pop && (q_ctl.kind == KIND_WRITE) &&
                          ({q_ctl.y_odd, q_ctl.x_odd} == 2'(b));

      always_ff @(posedge clock) begin
         if (bank_we[b]) begin
            mem[q_addr[b]] <= q_ctl.pixel;
         end
         if (adv) begin
            rdata_ff[b] <= mem[q_addr[b]];
         end
      end
   end

   logic          v1_ff;
   entry_ctl_type ctl1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl1_ff <= q_ctl;
      end
   end

   // ---- stage 2: neighbor select and horizontal blend ----
   function automatic logic [PIX_W-1:0] sel_bank(input logic [1:0] idx,
                                                 input logic [PIX_W-1:0] d0,
                                                 input logic [PIX_W-1:0] d1,
                                                 input logic [PIX_W-1:0] d2,
                                                 input logic [PIX_W-1:0] d3);
      logic [PIX_W-1:0] r;
      case (idx)
         2'd0:    r = d0;
         2'd1:    r = d1;
         2'd2:    r = d2;
         default: r = d3;
      endcase
      return r;
   endfunction

   logic             x1p, y1p;
   logic [PIX_W-1:0] p00, p01, p10, p11;
   logic [W_W-1:0]   wfx, wifx;
   logic [HRB_W-1:0] t_rb_in, b_rb_in;
   logic [HG_W-1:0]  t_g_in, b_g_in;

   always_comb begin
      x1p  = ctl1_ff.x_edge ? ctl1_ff.x_odd : !ctl1_ff.x_odd;
      y1p  = ctl1_ff.y_edge ? ctl1_ff.y_odd : !ctl1_ff.y_odd;
      p00  = sel_bank({ctl1_ff.y_odd, ctl1_ff.x_odd},
                      rdata_ff[0], rdata_ff[1], rdata_ff[2], rdata_ff[3]);
      p01  = sel_bank({ctl1_ff.y_odd, x1p},
                      rdata_ff[0], rdata_ff[1], rdata_ff[2], rdata_ff[3]);
      p10  = sel_bank({y1p, ctl1_ff.x_odd},
                      rdata_ff[0], rdata_ff[1], rdata_ff[2], rdata_ff[3]);
      p11  = sel_bank({y1p, x1p},
                      rdata_ff[0], rdata_ff[1], rdata_ff[2], rdata_ff[3]);
      wfx  = W_W'(ctl1_ff.fx);
      wifx = WEIGHT_ONE - wfx;
      t_rb_in = HRB_W'(p00 & RB_MASK) * HRB_W'(wifx) + HRB_W'(p01 & RB_MASK) * HRB_W'(wfx);
      b_rb_in = HRB_W'(p10 & RB_MASK) * HRB_W'(wifx) + HRB_W'(p11 & RB_MASK) * HRB_W'(wfx);
      t_g_in  = HG_W'(p00 & G_MASK) * HG_W'(wifx) + HG_W'(p01 & G_MASK) * HG_W'(wfx);
      b_g_in  = HG_W'(p10 & G_MASK) * HG_W'(wifx) + HG_W'(p11 & G_MASK) * HG_W'(wfx);
   end

   logic              v2_ff;
   kind_type          kind2_ff;
   logic [FRAC_W-1:0] fy2_ff;
   logic [PIX_W-1:0]  pixel2_ff;
   logic [HRB_W-1:0]  t_rb_ff, b_rb_ff;
   logic [HG_W-1:0]   t_g_ff, b_g_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff && (ctl1_ff.kind != KIND_WRITE);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind2_ff  <= ctl1_ff.kind;
         fy2_ff    <= ctl1_ff.fy;
         pixel2_ff <= ctl1_ff.pixel;
         t_rb_ff   <= t_rb_in;
         b_rb_ff   <= b_rb_in;
         t_g_ff    <= t_g_in;
         b_g_ff    <= b_g_in;
      end
   end

   // ---- stage 3: vertical blend and result register ----
   logic [W_W-1:0]   wfy, wify;
   logic [VRB_W-1:0] v_rb;
   logic [VG_W-1:0]  v_g;
   logic [PIX_W-1:0] blend, pixel_in;

   always_comb begin
      wfy   = W_W'(fy2_ff);
      wify  = WEIGHT_ONE - wfy;
      v_rb  = VRB_W'(t_rb_ff) * VRB_W'(wify) + VRB_W'(b_rb_ff) * VRB_W'(wfy);
      v_g   = VG_W'(t_g_ff) * VG_W'(wify) + VG_W'(b_g_ff) * VG_W'(wfy);
      blend = (PIX_W'(v_rb >> BLEND_SHIFT) & RB_MASK) |
              (PIX_W'(v_g >> BLEND_SHIFT) & G_MASK);
      case (kind2_ff)
         KIND_SCALED: pixel_in = blend;
         default:     pixel_in = pixel2_ff;
      endcase
   end

   logic             out_valid_ff;
   logic [PIX_W-1:0] out_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_pixel_ff <= pixel_in;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_frame_pixel = out_pixel_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) $onehot0(bank_we))
      else $error("more than one canvas bank written");
   assert property (@(posedge clock) disable iff (reset)
      (adv && v1_ff && ctl1_ff.kind == KIND_WRITE) |=> !v2_ff)
      else $error("canvas write produced a result");
`endif

endmodule

`default_nettype wire

/* sim/rgb565_bilinear_letterbox_scaler_unit_tb.sv */
// Self-checking testbench for rgb565_bilinear_letterbox_scaler_unit.
// Needs rbls_pkg and the scaler RTL; keeps its own canvas copy to predict
// every frame pixel read back.
`default_nettype none

module rgb565_bilinear_letterbox_scaler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rbls_pkg::*;

   // Geometry; matches the unit's default parameters
   localparam int SRC_W       = 184;
   localparam int SRC_H       = 224;
   localparam int OUT_W       = 368;
   localparam int OUT_H       = 448;
   localparam int FRAME_W     = 480;
   localparam int FRAME_H     = 480;
   localparam int CANVAS_SIZE = SRC_W * SRC_H;
   localparam int POS_MAX     = (1 << POS_W) - 1;

   // Centered destination window inside the frame
   localparam int WIN_X0 = (FRAME_W - OUT_W) / 2;
   localparam int WIN_Y0 = (FRAME_H - OUT_H) / 2;

   // 16.16 source step per destination pixel
   localparam longint FACTOR_X = (longint'(SRC_W) << 16) / OUT_W;
   localparam longint FACTOR_Y = (longint'(SRC_H) << 16) / OUT_H;

   // Alert bar rectangle, centered horizontally near the top
   localparam int BAR_W   = 200;
   localparam int BAR_H   = 8;
   localparam int BAR_TOP = 18;
   localparam int BAR_X0  = (FRAME_W - BAR_W) / 2;

   localparam logic [PIX_W-1:0] RB_MASK   = 16'hF81F;
   localparam logic [PIX_W-1:0] G_MASK    = 16'h07E0;
   localparam logic [PIX_W-1:0] BAR_COLOR = 16'hF800;
   localparam logic [PIX_W-1:0] BLACK     = 16'h0000;
   localparam logic [PIX_W-1:0] WHITE     = 16'hFFFF;
   localparam int               FRAC_ONE  = 32;

   localparam int MAX_GAP     = 10;
   localparam int PIPE_DRAIN  = 12;   // settle margin after the last pending read comes back
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_ITEMS = 250;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic              req_func;
   logic [POS_W-1:0]  req_pos_x;
   logic [POS_W-1:0]  req_pos_y;
   logic [PIX_W-1:0]  req_write_pixel;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [PIX_W-1:0]  rsp_frame_pixel;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_alert_bar_enable;

   // Predictor state: canvas copy, which entries hold data, bar setting
   logic [PIX_W-1:0]  canvas_copy [CANVAS_SIZE];
   bit                canvas_written [CANVAS_SIZE];
   bit                bar_enabled;

   logic [PIX_W-1:0]  pending_frame_pixels [$];
   int                requests_sent;
   int                pixels_checked;
   int                error_count;
   bit                req_burst;      // sender runs without gaps
   bit                rsp_burst;      // receiver pops without stalls

   rgb565_bilinear_letterbox_scaler_unit uut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_func             (req_func),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_write_pixel      (req_write_pixel),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_frame_pixel      (rsp_frame_pixel),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_alert_bar_enable (csr_alert_bar_enable)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

   //------------------------------------------------------------------
   // Predictor
   //------------------------------------------------------------------

   // Upper-left source index for destination coordinate d, plus its
   // clamped right/lower neighbor
   function automatic void source_span(input int d, input longint factor, input int size,
                                       output int lo, output int hi);
      longint s;
      s  = longint'(d) * factor;
      lo = int'(s >> 16);
      if (lo > size - 1)
         lo = size - 1;
      hi = (lo + 1 < size) ? lo + 1 : lo;
   endfunction

   // Bilinear blend of the four neighbors; red/blue and green kept apart
   function automatic logic [PIX_W-1:0] scaled_canvas_pixel(input int dx, input int dy);
      int x0, x1, y0, y1;
      int unsigned fx, fy, ifx, ify;
      int unsigned p00, p01, p10, p11;
      int unsigned t_rb, t_g, b_rb, b_g, rb, g;
      source_span(dx, FACTOR_X, SRC_W, x0, x1);
      source_span(dy, FACTOR_Y, SRC_H, y0, y1);
      fx  = int'((longint'(dx) * FACTOR_X) >> 11) & (FRAC_ONE - 1);
      fy  = int'((longint'(dy) * FACTOR_Y) >> 11) & (FRAC_ONE - 1);
      ifx = FRAC_ONE - fx;
      ify = FRAC_ONE - fy;
      p00 = canvas_copy[y0 * SRC_W + x0];
      p01 = canvas_copy[y0 * SRC_W + x1];
      p10 = canvas_copy[y1 * SRC_W + x0];
      p11 = canvas_copy[y1 * SRC_W + x1];
      t_rb = (p00 & RB_MASK) * ifx + (p01 & RB_MASK) * fx;
      t_g  = (p00 & G_MASK) * ifx + (p01 & G_MASK) * fx;
      b_rb = (p10 & RB_MASK) * ifx + (p11 & RB_MASK) * fx;
      b_g  = (p10 & G_MASK) * ifx + (p11 & G_MASK) * fx;
      rb = (t_rb * ify + b_rb * fy) >> 10;
      g  = (t_g * ify + b_g * fy) >> 10;
      return PIX_W'((rb & RB_MASK) | (g & G_MASK));
   endfunction

   // Frame pixel at (x, y): black border, scaled window, bar on top
   function automatic logic [PIX_W-1:0] predict_frame_pixel(input int x, input int y);
      logic [PIX_W-1:0] pix;
      int dx, dy;
      pix = BLACK;
      if (x < FRAME_W && y < FRAME_H) begin
         dx = x - WIN_X0;
         dy = y - WIN_Y0;
         if (dx >= 0 && dx < OUT_W && dy >= 0 && dy < OUT_H)
            pix = scaled_canvas_pixel(dx, dy);
         if (bar_enabled && y >= BAR_TOP && y < BAR_TOP + BAR_H &&
             x >= BAR_X0 && x < BAR_X0 + BAR_W)
            pix = BAR_COLOR;
      end
      return pix;
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0:       return BLACK;
         1:       return WHITE;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   //------------------------------------------------------------------
   // Request side
   //------------------------------------------------------------------

   // Drive one request at a falling edge, hold it until accepted, then
   // fold it into the predictor
   task automatic send_request(input logic func, input int x, input int y,
                               input logic [PIX_W-1:0] pixel);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push        <= 1'b1;
      req_func        <= func;
      req_pos_x       <= x[POS_W-1:0];
      req_pos_y       <= y[POS_W-1:0];
      req_write_pixel <= pixel;
      do @(posedge clock); while (req_full !== 1'b0);
      if (func == FUNC_READ) begin
         pending_frame_pixels.push_back(predict_frame_pixel(x, y));
      end else if (x < SRC_W && y < SRC_H) begin
         canvas_copy[y * SRC_W + x]    = pixel;
         canvas_written[y * SRC_W + x] = 1'b1;
      end
      requests_sent++;
   endtask

   task automatic fill_canvas_entry(input int x, input int y);
      if (!canvas_written[y * SRC_W + x])
         send_request(FUNC_WRITE, x, y, random_pixel());
   endtask

   // Read a frame pixel; any neighbor the scaler would fetch gets written
   // first so that no unwritten canvas entry is ever read
   task automatic read_pixel(input int x, input int y);
      int dx, dy, x0, x1, y0, y1;
      dx = x - WIN_X0;
      dy = y - WIN_Y0;
      if (x < FRAME_W && y < FRAME_H && dx >= 0 && dx < OUT_W && dy >= 0 && dy < OUT_H) begin
         source_span(dx, FACTOR_X, SRC_W, x0, x1);
         source_span(dy, FACTOR_Y, SRC_H, y0, y1);
         fill_canvas_entry(x0, y0);
         fill_canvas_entry(x1, y0);
         fill_canvas_entry(x0, y1);
         fill_canvas_entry(x1, y1);
      end
      send_request(FUNC_READ, x, y, PIX_W'($urandom));
   endtask

   // Stop sending and let every pending read come back
   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_frame_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // The bar enable is only touched while nothing is in flight
   task automatic write_alert_bar(input bit enable);
      wait_idle();
      @(negedge clock);
      csr_valid            <= 1'b1;
      csr_alert_bar_enable <= enable;
      do @(posedge clock); while (csr_ready !== 1'b1);
      bar_enabled = enable;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   //------------------------------------------------------------------
   // Response side: random pop stalls, each popped pixel checked in order
   //------------------------------------------------------------------

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%s", msg);
   endtask

   initial begin
      logic [PIX_W-1:0] want;
      int stall;
      rsp_pop   = 1'b0;
      rsp_burst = 1'b0;
      forever begin
         if ($urandom_range(0, 15) == 0)
            rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         @(negedge clock);
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (reset || rsp_empty !== 1'b0);
         if (pending_frame_pixels.size() == 0) begin
            note_failure($sformatf("unexpected response %h with no read pending",
                                   rsp_frame_pixel));
         end else begin
            want = pending_frame_pixels.pop_front();
            if (rsp_frame_pixel !== want)
               note_failure($sformatf("frame pixel %0d: expected %h, got %h",
                                      pixels_checked, want, rsp_frame_pixel));
         end
         pixels_checked++;
      end
   end

   //------------------------------------------------------------------
   // Tests
   //------------------------------------------------------------------

   // Canvas corners with extreme colors, window corners, edge clamping,
   // and writes that fall outside the canvas
   task automatic test_canvas_corners();
      send_request(FUNC_WRITE, 0, 0, WHITE);
      send_request(FUNC_WRITE, SRC_W - 1, 0, BLACK);
      send_request(FUNC_WRITE, 0, SRC_H - 1, RB_MASK);
      send_request(FUNC_WRITE, SRC_W - 1, SRC_H - 1, G_MASK);
      read_pixel(WIN_X0, WIN_Y0);
      read_pixel(WIN_X0 + 1, WIN_Y0 + 1);
      read_pixel(WIN_X0 + OUT_W - 2, WIN_Y0);
      // last column/row: right and lower neighbors clamp onto themselves
      read_pixel(WIN_X0 + OUT_W - 1, WIN_Y0 + OUT_H - 1);
      // dropped writes; a wrap into the canvas would show on the re-read
      send_request(FUNC_WRITE, SRC_W, 0, WHITE);
      send_request(FUNC_WRITE, 0, SRC_H, WHITE);
      send_request(FUNC_WRITE, POS_MAX, POS_MAX, WHITE);
      read_pixel(WIN_X0, WIN_Y0);
      read_pixel(WIN_X0 + 1, WIN_Y0 + 2);
   endtask

   // Black border around the window and reads past the frame
   task automatic test_frame_border();
      read_pixel(0, 0);
      read_pixel(FRAME_W - 1, FRAME_H - 1);
      read_pixel(WIN_X0 - 1, WIN_Y0);
      read_pixel(WIN_X0, WIN_Y0 - 1);
      read_pixel(WIN_X0 + OUT_W, WIN_Y0 + OUT_H - 1);
      read_pixel(FRAME_W, 0);
      read_pixel(0, FRAME_H);
      read_pixel(POS_MAX, POS_MAX);
   endtask

   // Bar edges with the bar on, then the same spot with it off
   task automatic test_alert_bar();
      write_alert_bar(1'b1);
      read_pixel(BAR_X0, BAR_TOP);
      read_pixel(BAR_X0 + BAR_W - 1, BAR_TOP + BAR_H - 1);
      read_pixel(BAR_X0 - 1, BAR_TOP);
      read_pixel(BAR_X0 + BAR_W - 1, BAR_TOP + BAR_H);
      read_pixel(POS_MAX, BAR_TOP);
      write_alert_bar(1'b0);
      read_pixel(BAR_X0, BAR_TOP);
   endtask

   task automatic random_request();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         send_request(FUNC_WRITE, $urandom_range(0, SRC_W - 1),
                      $urandom_range(0, SRC_H - 1), random_pixel());
      end else if (sel < 35) begin
         if ($urandom_range(0, 1))
            send_request(FUNC_WRITE, $urandom_range(SRC_W, POS_MAX),
                         $urandom_range(0, POS_MAX), random_pixel());
         else
            send_request(FUNC_WRITE, $urandom_range(0, POS_MAX),
                         $urandom_range(SRC_H, POS_MAX), random_pixel());
      end else if (sel < 75) begin
         read_pixel(WIN_X0 + $urandom_range(0, OUT_W - 1),
                    WIN_Y0 + $urandom_range(0, OUT_H - 1));
      end else if (sel < 85) begin
         read_pixel($urandom_range(0, FRAME_W - 1), $urandom_range(0, FRAME_H - 1));
      end else if (sel < 92) begin
         // around the bar so both sides of each edge get hit
         read_pixel($urandom_range(BAR_X0 - 4, BAR_X0 + BAR_W + 3),
                    $urandom_range(BAR_TOP - 3, BAR_TOP + BAR_H + 2));
      end else begin
         if ($urandom_range(0, 1))
            read_pixel($urandom_range(FRAME_W, POS_MAX), $urandom_range(0, POS_MAX));
         else
            read_pixel($urandom_range(0, POS_MAX), $urandom_range(FRAME_H, POS_MAX));
      end
   endtask

   // Phases of mixed traffic; the bar setting changes between phases and
   // each change drains the pipe first
   task automatic test_random_traffic();
      int target;
      for (int phase = 0; phase < 5; phase++) begin
         write_alert_bar(phase == 4 ? bit'($urandom_range(0, 1)) : (phase % 2 == 0));
         req_burst = (phase == 2) || ($urandom_range(0, 3) == 0);
         target = requests_sent + PHASE_ITEMS;
         while (requests_sent < target)
            random_request();
      end
      req_burst = 1'b0;
   endtask

   initial begin
      reset                = 1'b1;
      req_push             = 1'b0;
      req_func             = FUNC_WRITE;
      req_pos_x            = '0;
      req_pos_y            = '0;
      req_write_pixel      = '0;
      csr_valid            = 1'b0;
      csr_alert_bar_enable = 1'b0;
      bar_enabled          = 1'b0;
      req_burst            = 1'b0;
      requests_sent        = 0;
      pixels_checked       = 0;
      error_count          = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_canvas_corners();
      test_frame_border();
      test_alert_bar();
      test_random_traffic();
      wait_idle();

      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
